FILE: hdl/mcwj_pkg.sv
// ----------------------------------------------------------------------------
// mcwj_pkg: shared types for the window jump cost unit
// Controller states, command and status bundles, register decode.
// ----------------------------------------------------------------------------
`default_nettype none
package mcwj_pkg;

  localparam int unsigned COST_W = 32;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MJ_W   = 8;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // word index of the max_jump register (paddr bit 2)
  localparam logic REG_MAX_JUMP = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic rem_zero;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage : mcwj_pkg
`default_nettype wire

FILE: hdl/mcwj_regs.sv
// ----------------------------------------------------------------------------
// mcwj_regs: configuration register file
// APB-style slave holding the max_jump register.
// ----------------------------------------------------------------------------
`default_nettype none
module mcwj_regs
  import mcwj_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [MJ_W-1:0]   max_jump_o
);

  logic [MJ_W-1:0] max_jump_q, max_jump_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_JUMP);

  always_comb begin
    max_jump_d = max_jump_q;
    if (wr_en) begin
      max_jump_d = pwdata[MJ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jump_q <= MJ_W'(1);
    end else begin
      max_jump_q <= max_jump_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_JUMP) begin
      prdata = DATA_W'(max_jump_q);
    end
  end

  assign max_jump_o = max_jump_q;

endmodule : mcwj_regs
`default_nettype wire

FILE: hdl/mcwj_ctrl.sv
// ----------------------------------------------------------------------------
// mcwj_ctrl: sequencing controller
// Steps one stone through window scan, pipeline drain and write-back.
// ----------------------------------------------------------------------------
`default_nettype none
module mcwj_ctrl
  import mcwj_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.skip ? ST_FIN : ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (status_i.rem_zero) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.start  = in_valid_i;
      end
      ST_LOOP: begin
        cmd_o.issue  = !status_i.rem_zero;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_FIN: begin
        cmd_o.finish = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : mcwj_ctrl
`default_nettype wire

FILE: hdl/mcwj_dp.sv
// ----------------------------------------------------------------------------
// mcwj_dp: window datapath
// Ring window memory, scan pointers, add-compare pipeline, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mcwj_dp
  import mcwj_pkg::*;
#(
  parameter int unsigned MAX_JUMP    = 128,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [HEIGHT_BITS-1:0] height_i,
  input  wire logic                   first_stone_i,
  input  wire logic [MJ_W-1:0]        max_jump_i,
  input  wire cmd_t                   cmd_i,
  output status_t                     status_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [COST_W-1:0]      cost_o
);

  localparam int unsigned PTR_W = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_JUMP + 1);
  localparam int unsigned LIM_W = (CNT_W > MJ_W) ? CNT_W : MJ_W;
  localparam int unsigned ENT_W = HEIGHT_BITS + COST_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_JUMP - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_JUMP);

  logic [ENT_W-1:0] mem [MAX_JUMP];

  logic [PTR_W-1:0]       ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]       stones_q, rem_q;
  logic [HEIGHT_BITS-1:0] h_q;
  logic [COST_W-1:0]      best_q, cand_q, ccost_q, out_cost_q;
  logic [HEIGHT_BITS-1:0] diff_q;
  logic [ENT_W-1:0]       rdata_q;
  logic                   v0_q, v1_q, v2_q, out_valid_q;

  logic [CNT_W-1:0]       stones_eff;
  logic [LIM_W-1:0]       mj_eff, lim;
  logic [HEIGHT_BITS-1:0] rd_h;
  logic [COST_W:0]        sum;
  logic                   out_free;

  assign stones_eff = first_stone_i ? '0 : stones_q;

  always_comb begin
    mj_eff = LIM_W'(max_jump_i);
    if (mj_eff == '0) begin
      mj_eff = LIM_W'(1);
    end
    if (mj_eff > LIM_W'(MAX_JUMP)) begin
      mj_eff = LIM_W'(MAX_JUMP);
    end
    lim = mj_eff;
    if (lim > LIM_W'(stones_eff)) begin
      lim = LIM_W'(stones_eff);
    end
  end

  assign rd_h     = rdata_q[ENT_W-1:COST_W];
  assign sum      = {1'b0, ccost_q} + (COST_W + 1)'(diff_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem[rd_ptr_q];
    end
    if (cmd_i.finish) begin
      mem[ptr_q] <= {h_q, best_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      h_q      <= height_i;
      best_q   <= (stones_eff == '0) ? '0 : COST_MAX;
      rd_ptr_q <= (ptr_q == '0) ? PTR_LAST : ptr_q - PTR_W'(1);
      rem_q    <= lim[CNT_W-1:0];
    end else begin
      if (cmd_i.issue) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? PTR_LAST : rd_ptr_q - PTR_W'(1);
        rem_q    <= rem_q - CNT_W'(1);
      end
      if (v2_q && (cand_q < best_q)) begin
        best_q <= cand_q;
      end
    end
    if (v0_q) begin
      diff_q  <= (h_q >= rd_h) ? h_q - rd_h : rd_h - h_q;
      ccost_q <= rdata_q[COST_W-1:0];
    end
    if (v1_q) begin
      cand_q <= sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    end
    if (cmd_i.finish) begin
      out_cost_q <= best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      stones_q    <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        stones_q <= (stones_eff == CNT_FULL) ? CNT_FULL : stones_eff + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        ptr_q       <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.skip       = (stones_eff == '0);
    status_o.rem_zero   = (rem_q == '0);
    status_o.pipe_empty = !v0_q && !v1_q && !v2_q;
    status_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign cost_o      = out_cost_q;

endmodule : mcwj_dp
`default_nettype wire

FILE: hdl/min_cost_window_jump_dp_unit.sv
// ----------------------------------------------------------------------------
// min_cost_window_jump_dp_unit: minimum jump cost over a sliding window
// Each stone scans limit window entries, one per cycle, where limit =
// min(max_jump, stones held in the row); a first stone of a row scans none.
// A new stone is taken only once the cost of the last one is registered.
// Reset clears the write pointer, stone count, valids, sets max_jump to 1;
// the window memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module min_cost_window_jump_dp_unit
  import mcwj_pkg::*;
#(
  parameter int unsigned MAX_JUMP    = 128,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [HEIGHT_BITS-1:0] height_i,
  input  wire logic                   first_stone_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [COST_W-1:0]      cost_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_W-1:0]      paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic      [DATA_W-1:0]      prdata,
  output logic                        pready
);

  logic [MJ_W-1:0] max_jump;
  cmd_t            cmd;
  status_t         status;

  mcwj_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_jump_o (max_jump)
  );

  mcwj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcwj_dp #(
    .MAX_JUMP    (MAX_JUMP),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .height_i      (height_i),
    .first_stone_i (first_stone_i),
    .max_jump_i    (max_jump),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cost_o        (cost_o)
  );

endmodule : min_cost_window_jump_dp_unit
`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for min_cost_window_jump_dp_unit
// Streams rows of stone heights through the valid/stall input, predicts the
// minimum jump cost of every stone and compares each cost transaction in order.
// max_jump is rewritten over the APB port between phases (0, 1, 128, 255 and
// values between). Both sides idle in random bursts, the receiver holds off
// once for a long stretch, and a final back-to-back row runs with no idling.
// ----------------------------------------------------------------------------
module testbench
  import mcwj_pkg::*;
();

  localparam int unsigned MAX_JUMP     = 128;
  localparam int unsigned HEIGHT_BITS  = 16;
  localparam int unsigned DRAIN_CYCLES = MAX_JUMP + 8;
  localparam int unsigned HOLD_CYCLES  = 700;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned MAX_REPORTS  = 50;
  localparam int unsigned TAIL_STONES  = 30;
  localparam logic [ADDR_W-1:0] MAX_JUMP_ADDR = {REG_MAX_JUMP, 2'b00};

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    logic                   first;
  } stone_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [HEIGHT_BITS-1:0] height_i = '0;
  logic                   first_stone_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [COST_W-1:0]      cost_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  // predictor state
  logic [HEIGHT_BITS-1:0] row_heights [MAX_JUMP];
  logic [COST_W-1:0]      row_costs [MAX_JUMP];
  int unsigned            next_slot = 0;
  int unsigned            stones_held = 0;
  logic [MJ_W-1:0]        jump_cfg = 8'd1;

  stone_t                 stone_q [$];
  logic [COST_W-1:0]      cost_q [$];

  int unsigned send_gap_odds = 0;
  int unsigned recv_stall_odds = 0;
  bit          hold_req = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stones_sent = 0;
  int unsigned costs_checked = 0;
  int unsigned settings_used = 0;
  int unsigned fails = 0;
  int unsigned cycle_count = 0;

  min_cost_window_jump_dp_unit #(
    .MAX_JUMP   (MAX_JUMP),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .height_i     (height_i),
    .first_stone_i(first_stone_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cost_o       (cost_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // least cost to reach this stone; updates the row history
  function automatic logic [COST_W-1:0] stone_cost(input logic [HEIGHT_BITS-1:0] h,
                                                   input logic first);
    int unsigned          span;
    int unsigned          j;
    int unsigned          slot;
    logic [HEIGHT_BITS-1:0] step_gap;
    logic [COST_W:0]      cand;
    logic [COST_W:0]      best;
    logic [COST_W-1:0]    result;
    result = '0;
    if (first) stones_held = 0;
    if (stones_held != 0) begin
      span = (jump_cfg == 0) ? 1 : jump_cfg;
      if (span > MAX_JUMP) span = MAX_JUMP;
      if (span > stones_held) span = stones_held;
      best = {1'b0, COST_MAX};
      for (j = 1; j <= span; j++) begin
        slot = (next_slot + MAX_JUMP - j) % MAX_JUMP;
        step_gap = (h >= row_heights[slot]) ? h - row_heights[slot] : row_heights[slot] - h;
        cand = {1'b0, row_costs[slot]} + step_gap;
        if (cand > {1'b0, COST_MAX}) cand = {1'b0, COST_MAX};
        if (cand < best) best = cand;
      end
      result = best[COST_W-1:0];
    end
    row_heights[next_slot] = h;
    row_costs[next_slot] = result;
    next_slot = (next_slot + 1) % MAX_JUMP;
    if (stones_held < MAX_JUMP) stones_held++;
    return result;
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_proc
    stone_t s;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cost_q.push_back(stone_cost(height_i, first_stone_i));
        stones_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (stone_q.size() != 0 && send_gap_odds != 0 &&
                     $urandom_range(0, send_gap_odds - 1) == 0) begin
          gap_left = $urandom_range(0, 18);
          in_valid_i <= 1'b0;
        end else if (stone_q.size() != 0) begin
          s = stone_q.pop_front();
          height_i <= s.height;
          first_stone_i <= s.first;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin : check_proc
    logic [COST_W-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cost_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $error("cost: no transaction expected, actual %0d", cost_o);
        end else begin
          want = cost_q.pop_front();
          costs_checked++;
          if (cost_o !== want) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $error("cost mismatch: expected %0d, actual %0d", want, cost_o);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (recv_stall_odds != 0 && $urandom_range(0, recv_stall_odds - 1) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("min_cost_window_jump_dp_unit verification failed");
      $finish;
    end
  end

  task automatic push_stone(input logic [HEIGHT_BITS-1:0] h, input logic f);
    stone_t s;
    s.height = h;
    s.first = f;
    stone_q.push_back(s);
  endtask

  task automatic settle();
    while (stone_q.size() != 0 || in_valid_i || cost_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_jump(input logic [MJ_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_JUMP_ADDR;
    pwdata <= {{(DATA_W-MJ_W){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    jump_cfg = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[MJ_W-1:0] !== val) begin
      fails++;
      $error("max_jump readback mismatch: expected %0d, actual %0d", val, prdata[MJ_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    settings_used++;
    @(negedge clk_i);
  endtask

  task automatic queue_rows(input int unsigned count);
    stone_t s;
    int unsigned left;
    int unsigned style;
    int unsigned k;
    logic [HEIGHT_BITS-1:0] base;
    left = 0;
    style = 0;
    base = '0;
    for (k = 0; k < count; k++) begin
      s.first = 1'b0;
      if (left == 0) begin
        left = ($urandom_range(0, 2) == 0) ? $urandom_range(130, 260) : $urandom_range(1, 60);
        style = $urandom_range(0, 3);
        base = HEIGHT_BITS'($urandom);
        s.first = ($urandom_range(0, 5) != 0);
      end else if ($urandom_range(0, 39) == 0) begin
        s.first = 1'b1;
      end
      case (style)
        0: s.height = HEIGHT_BITS'($urandom);
        1: begin
          base = base + HEIGHT_BITS'($urandom_range(0, 62)) - HEIGHT_BITS'(31);
          s.height = base;
        end
        2: s.height = ($urandom_range(0, 1) != 0) ? '1 : '0;
        default: s.height = HEIGHT_BITS'($urandom_range(0, 15));
      endcase
      left--;
      stone_q.push_back(s);
    end
  endtask

  initial begin : stimulus
    logic [MJ_W-1:0] jumps [10];
    int unsigned p;
    int unsigned k;
    jumps = '{8'd2, 8'd128, 8'd1, 8'd17, 8'd255, 8'd64, 8'd0, 8'd5, 8'd128, 8'd0};
    jumps[9] = MJ_W'($urandom_range(1, 255));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value of max_jump; first stone arrives without a row marker
    push_stone(16'hFFFF, 1'b0);
    push_stone(16'h0000, 1'b0);
    push_stone(16'hAAAA, 1'b0);
    push_stone(16'h5555, 1'b0);
    push_stone(16'h0000, 1'b1);
    push_stone(16'hFFFF, 1'b0);
    settle();
    // zero behaves as one
    write_jump(8'd0);
    push_stone(16'h1000, 1'b1);
    push_stone(16'h0FFF, 1'b0);
    push_stone(16'h1001, 1'b0);
    push_stone(16'h8000, 1'b0);
    settle();
    // above the window depth, clamped
    write_jump(8'd255);
    push_stone(16'd100, 1'b1);
    push_stone(16'd5, 1'b0);
    push_stone(16'd300, 1'b0);
    push_stone(16'd90, 1'b0);
    push_stone(16'd101, 1'b0);
    push_stone(16'hFFFF, 1'b0);
    push_stone(16'h0000, 1'b0);
    push_stone(16'd99, 1'b0);
    settle();
    write_jump(8'd3);
    push_stone(16'd10, 1'b1);
    push_stone(16'd50, 1'b0);
    push_stone(16'd10, 1'b0);
    push_stone(16'd50, 1'b0);
    push_stone(16'd12, 1'b0);
    push_stone(16'd0, 1'b1);
    settle();

    for (p = 0; p < 10; p++) begin
      write_jump(jumps[p]);
      case (p % 3)
        0: begin send_gap_odds = 0; recv_stall_odds = 6; end
        1: begin send_gap_odds = 4; recv_stall_odds = 0; end
        default: begin send_gap_odds = 10; recv_stall_odds = 3; end
      endcase
      if (p == 0) hold_req = 1'b1;
      queue_rows(50);
      settle();
    end

    // closing row, no idling
    send_gap_odds = 0;
    recv_stall_odds = 0;
    write_jump(8'd1);
    for (k = 0; k < TAIL_STONES; k++) push_stone((k % 2 == 0) ? 16'h0000 : 16'hFFFF, k == 0);
    settle();

    $display("checked %0d cost transactions of %0d stones over %0d max_jump writes",
             costs_checked, stones_sent, settings_used);
    $display("rows up to 260 stones with window wrap, clamps at 0 and 255, closing burst row");
    if (fails == 0) begin
      $display("min_cost_window_jump_dp_unit verification clean");
    end else begin
      $display("min_cost_window_jump_dp_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mcwj_pkg.sv
hdl/mcwj_regs.sv
hdl/mcwj_ctrl.sv
hdl/mcwj_dp.sv
hdl/min_cost_window_jump_dp_unit.sv
tb/sv/testbench.sv
